>>> hdl/qrm_pkg.sv
package qrm_pkg;

  localparam int IN_W  = 16;
  localparam int FRAC  = 14;
  localparam int OUT_W = FRAC + 2;
  localparam int PW    = 2 * IN_W;
  localparam int DW    = PW + 2;
  localparam int QW    = FRAC + 1;
  localparam int NE    = 9;

  localparam logic [QW-1:0] ONE_Q = QW'(1) << FRAC;

endpackage

>>> hdl/qrm_if.sv
interface qrm_in_if;
  import qrm_pkg::*;
  logic                    valid;
  logic                    ready;
  logic signed [IN_W-1:0]  qw;
  logic signed [IN_W-1:0]  qx;
  logic signed [IN_W-1:0]  qy;
  logic signed [IN_W-1:0]  qz;
  modport source (output valid, qw, qx, qy, qz, input ready);
  modport sink (input valid, qw, qx, qy, qz, output ready);
endinterface

interface qrm_out_if;
  import qrm_pkg::*;
  logic                    valid;
  logic                    ready;
  logic signed [OUT_W-1:0] e00;
  logic signed [OUT_W-1:0] e01;
  logic signed [OUT_W-1:0] e02;
  logic signed [OUT_W-1:0] e10;
  logic signed [OUT_W-1:0] e11;
  logic signed [OUT_W-1:0] e12;
  logic signed [OUT_W-1:0] e20;
  logic signed [OUT_W-1:0] e21;
  logic signed [OUT_W-1:0] e22;
  logic                    zero_norm;
  modport source (output valid, e00, e01, e02, e10, e11, e12, e20, e21, e22, zero_norm,
                  input ready);
  modport sink (input valid, e00, e01, e02, e10, e11, e12, e20, e21, e22, zero_norm,
                output ready);
endinterface

>>> hdl/quaternion_to_rotation_matrix_core.sv
// quaternion to 3x3 rotation matrix, Q1.14 results
// quat (sink): one quaternion qw, qx, qy, qz per beat, signed 16-bit, any scale
// mat (source): nine entries e00..e22 in row-major order, rounded to nearest
//   (ties away from zero), clamped to +-1.0, plus zero_norm for an all-zero
//   quaternion, which gives the identity matrix
// path: an accepted quat beat goes through the input, product, norm/magnitude, division and output registers
// throughput: one beat per cycle unless mat stalls; the 15 bit-per-stage division
//   stages, run as nine lanes against a shared squared norm, set the depth
// the whole pipeline advances together whenever the output register is empty
//   or taken; while mat.ready is low with a result waiting, every stage holds
//   and quat.ready is low, so nothing is lost or repeated
// reset (synchronous, rst high) clears all valid bits; data is left as is
module quaternion_to_rotation_matrix_core import qrm_pkg::*; (
  input logic      clk,
  input logic      rst,
  qrm_in_if.sink   quat,
  qrm_out_if.source mat
);

  logic en;
  logic v1, v2, v3, vo;
  logic vd [0:FRAC];

  logic signed [IN_W-1:0] rw, rx, ry, rz;
  logic signed [PW-1:0] ww, xx, yy, zz, xy, zw, xz, yw, yz, xw;

  logic [DW-1:0] sa [0:NE-1];
  logic          sn [0:NE-1];
  logic [DW-1:0] sno;
  logic          sz;

  logic [DW-1:0] dr [0:FRAC][0:NE-1];
  logic [QW-1:0] dq [0:FRAC][0:NE-1];
  logic          dn [0:FRAC][0:NE-1];
  logic [DW-1:0] dno [0:FRAC];
  logic          dz [0:FRAC];

  logic signed [OUT_W-1:0] eo [0:NE-1];
  logic                    zo;

  logic signed [DW-1:0] val [0:NE-1];
  logic [DW-1:0]        nsum;
  logic [OUT_W-1:0]     res [0:NE-1];

  function automatic logic signed [DW-1:0] ext(input logic signed [PW-1:0] p);
    return DW'(p);
  endfunction

  assign en = !vo || mat.ready;
  assign quat.ready = en;

  always_comb begin
    nsum = DW'(ww) + DW'(xx) + DW'(yy) + DW'(zz);
    val[0] = (ext(ww) + ext(xx)) - (ext(yy) + ext(zz));
    val[4] = (ext(ww) + ext(yy)) - (ext(xx) + ext(zz));
    val[8] = (ext(ww) + ext(zz)) - (ext(xx) + ext(yy));
    val[1] = (ext(xy) + ext(zw)) <<< 1;
    val[2] = (ext(xz) - ext(yw)) <<< 1;
    val[3] = (ext(xy) - ext(zw)) <<< 1;
    val[5] = (ext(yz) + ext(xw)) <<< 1;
    val[6] = (ext(xz) + ext(yw)) <<< 1;
    val[7] = (ext(yz) - ext(xw)) <<< 1;
  end

  always_comb begin
    for (int l = 0; l < NE; l++) begin
      logic [QW-1:0] qr;
      qr = dq[FRAC][l] + QW'({dr[FRAC][l], 1'b0} >= {1'b0, dno[FRAC]});
      if (qr > ONE_Q) begin
        qr = ONE_Q;
      end
      if (dz[FRAC]) begin
        res[l] = (l == 0 || l == 4 || l == 8) ? OUT_W'(ONE_Q) : '0;
      end else begin
        res[l] = dn[FRAC][l] ? OUT_W'(-OUT_W'(qr)) : OUT_W'(qr);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
      v2 <= 1'b0;
      v3 <= 1'b0;
      vo <= 1'b0;
      for (int i = 0; i <= FRAC; i++) begin
        vd[i] <= 1'b0;
      end
    end else if (en) begin
      v1 <= quat.valid;
      v2 <= v1;
      v3 <= v2;
      vd[0] <= v3;
      for (int i = 1; i <= FRAC; i++) begin
        vd[i] <= vd[i-1];
      end
      vo <= vd[FRAC];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      rw <= quat.qw;
      rx <= quat.qx;
      ry <= quat.qy;
      rz <= quat.qz;

      ww <= rw * rw;
      xx <= rx * rx;
      yy <= ry * ry;
      zz <= rz * rz;
      xy <= rx * ry;
      zw <= rz * rw;
      xz <= rx * rz;
      yw <= ry * rw;
      yz <= ry * rz;
      xw <= rx * rw;

      sno <= nsum;
      sz  <= (nsum == '0);
      for (int l = 0; l < NE; l++) begin
        sn[l] <= val[l][DW-1];
        sa[l] <= val[l][DW-1] ? DW'(-val[l]) : DW'(val[l]);
      end

      dno[0] <= sno;
      dz[0]  <= sz;
      for (int l = 0; l < NE; l++) begin
        dn[0][l] <= sn[l];
        if (sa[l] >= sno) begin
          dq[0][l] <= QW'(1);
          dr[0][l] <= '0;
        end else begin
          dq[0][l] <= '0;
          dr[0][l] <= sa[l];
        end
      end

      for (int i = 1; i <= FRAC; i++) begin
        dno[i] <= dno[i-1];
        dz[i]  <= dz[i-1];
        for (int l = 0; l < NE; l++) begin
          logic [DW:0] t;
          t = {dr[i-1][l], 1'b0};
          dn[i][l] <= dn[i-1][l];
          if (t >= {1'b0, dno[i-1]}) begin
            dq[i][l] <= {dq[i-1][l][QW-2:0], 1'b1};
            dr[i][l] <= DW'(t - {1'b0, dno[i-1]});
          end else begin
            dq[i][l] <= {dq[i-1][l][QW-2:0], 1'b0};
            dr[i][l] <= DW'(t);
          end
        end
      end

      for (int l = 0; l < NE; l++) begin
        eo[l] <= res[l];
      end
      zo <= dz[FRAC];
    end
  end

  assign mat.valid     = vo;
  assign mat.e00       = eo[0];
  assign mat.e01       = eo[1];
  assign mat.e02       = eo[2];
  assign mat.e10       = eo[3];
  assign mat.e11       = eo[4];
  assign mat.e12       = eo[5];
  assign mat.e20       = eo[6];
  assign mat.e21       = eo[7];
  assign mat.e22       = eo[8];
  assign mat.zero_norm = zo;

endmodule
